/* hdl/shd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shd_pkg : shared types and constants for the half-step stepper driver
// Command codes, register indexes, period width and the half-step table.
// ----------------------------------------------------------------------------
package shd_pkg;

    // Width of the period, target and tick counter registers
    localparam int PERIOD_WIDTH = 16;
    // Width of the reported target and period fields and of the register reset values
    localparam int REPORT_WIDTH = 16;
    localparam int OP_WIDTH     = 3;
    localparam int COIL_WIDTH   = 4;
    localparam int PHASE_WIDTH  = 3;
    localparam int REG_IDX_W    = 2;

    typedef logic [PERIOD_WIDTH-1:0] period_t;
    typedef logic [REPORT_WIDTH-1:0] report_t;
    typedef logic [COIL_WIDTH-1:0]   coil_t;
    typedef logic [PHASE_WIDTH-1:0]  phase_t;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_SET    = 3'd3,
        OP_FASTER = 3'd4,
        OP_SLOWER = 3'd5
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOWEST = 2'd0,
        REG_FASTEST = 2'd1,
        REG_DEFAULT = 2'd2
    } reg_idx_t;

    // Register reset values
    localparam report_t SLOWEST_RST = 16'd2000;
    localparam report_t FASTEST_RST = 16'd200;
    localparam report_t DEFAULT_RST = 16'd1000;

    // One result as handed to the output side
    typedef struct packed {
        coil_t   coil_pattern;
        logic    coil_enable;
        logic    step_fired;
        logic    is_running;
        report_t target_now;
        report_t period_now;
    } result_t;

    // Half-step coil sequence
    function automatic coil_t half_step(input phase_t idx);
        coil_t pat;
        begin
            case (idx)
                3'd0:    pat = 4'h2;
                3'd1:    pat = 4'h6;
                3'd2:    pat = 4'h4;
                3'd3:    pat = 4'h5;
                3'd4:    pat = 4'h1;
                3'd5:    pat = 4'h9;
                3'd6:    pat = 4'h8;
                3'd7:    pat = 4'hA;
                default: pat = 4'h0;
            endcase
            return pat;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/stepper_halfstep_ramp_driver.sv */
`default_nettype none
// The result of an accepted request is registered into the output buffer.
// Throughput: one request per cycle while in_stall is low; the state update is a single registered pass.
// A two-entry output buffer lets requests flow while one result waits to be taken.
// Reset (rst_n low, asynchronous): motor stopped, coils off, index and periods 0,
// target and limit registers back to their defaults, output buffer empty.
// ----------------------------------------------------------------------------
// stepper_halfstep_ramp_driver : four-coil half-step driver with speed ramp
// Counts ticks against the current period, steps the coils on a match and
// ramps the period one count per step toward the target, except on the step that wraps the phase index.
// ----------------------------------------------------------------------------
module stepper_halfstep_ramp_driver (
    input  wire                          clk,
    input  wire                          rst_n,
    // request channel
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [shd_pkg::OP_WIDTH-1:0] operation,
    input  wire  [15:0]                  speed_value,
    // result channel
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [3:0]                   coil_pattern,
    output logic                         coil_enable,
    output logic                         step_fired,
    output logic                         is_running,
    output logic [15:0]                  target_now,
    output logic [15:0]                  period_now,
    // register write port
    input  wire                          wr_en,
    input  wire  [shd_pkg::REG_IDX_W-1:0] wr_index,
    input  wire  [15:0]                  wr_data
);
    import shd_pkg::*;

    // limit registers
    period_t slowest_reg;
    period_t fastest_reg;

    // motor state
    logic    running_reg,  running_next;
    phase_t  phase_reg,    phase_next;
    period_t period_reg,   period_next;
    period_t target_reg,   target_next;
    period_t count_reg,    count_next;
    coil_t   coil_reg,     coil_next;
    logic    fired;

    // output buffer: main stage and skid stage
    result_t out_reg,      result_next;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    logic    accept;
    logic    pop;
    period_t value_in;

    assign accept   = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign value_in = PERIOD_WIDTH'(speed_value);

    // Write the limit registers; the default target only matters at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slowest_reg <= PERIOD_WIDTH'(SLOWEST_RST);
            fastest_reg <= PERIOD_WIDTH'(FASTEST_RST);
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_SLOWEST: slowest_reg <= PERIOD_WIDTH'(wr_data);
                REG_FASTEST: fastest_reg <= PERIOD_WIDTH'(wr_data);
                default:     ;
            endcase
        end
    end

    // Work out the next motor state for one request
    always_comb
    begin
        running_next = running_reg;
        phase_next   = phase_reg;
        period_next  = period_reg;
        target_next  = target_reg;
        count_next   = count_reg;
        coil_next    = coil_reg;
        fired        = 1'b0;
        case (op_t'(operation))
            OP_TICK:
            begin
                if (running_reg)
                begin
                    if (count_reg != period_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        fired      = 1'b1;
                        count_next = '0;
                        coil_next  = half_step(phase_reg);
                        phase_next = phase_reg + 1'b1;
                        // ramp one count toward the target, but not on wrap
                        if (phase_next != '0)
                        begin
                            if (period_reg > target_reg)
                                period_next = period_reg - 1'b1;
                            else if (period_reg < target_reg)
                                period_next = period_reg + 1'b1;
                        end
                    end
                end
            end
            OP_START:
            begin
                if (!running_reg)
                begin
                    period_next  = slowest_reg;
                    count_next   = '0;
                    running_next = 1'b1;
                end
            end
            OP_STOP:
            begin
                coil_next    = '0;
                running_next = 1'b0;
            end
            OP_SET:
            begin
                if (value_in <= slowest_reg && value_in >= fastest_reg)
                    target_next = value_in;
            end
            OP_FASTER:
            begin
                target_next = (target_reg <= fastest_reg) ? fastest_reg
                                                          : target_reg - 1'b1;
            end
            OP_SLOWER:
            begin
                target_next = (target_reg >= slowest_reg) ? slowest_reg
                                                          : target_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Hold the motor state, advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            phase_reg   <= '0;
            period_reg  <= '0;
            target_reg  <= PERIOD_WIDTH'(DEFAULT_RST);
            count_reg   <= '0;
            coil_reg    <= '0;
        end
        else if (accept)
        begin
            running_reg <= running_next;
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            target_reg  <= target_next;
            count_reg   <= count_next;
            coil_reg    <= coil_next;
        end
    end

    // Assemble the result of this request
    always_comb
    begin
        result_next.coil_pattern = coil_next;
        result_next.coil_enable  = running_next;
        result_next.step_fired   = fired;
        result_next.is_running   = running_next;
        result_next.target_now   = REPORT_WIDTH'(target_next);
        result_next.period_now   = REPORT_WIDTH'(period_next);
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output buffer data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_reg <= result_next;
            else
                out_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = out_reg.coil_pattern;
    assign coil_enable  = out_reg.coil_enable;
    assign step_fired   = out_reg.step_fired;
    assign is_running   = out_reg.is_running;
    assign target_now   = out_reg.target_now;
    assign period_now   = out_reg.period_now;

endmodule
`default_nettype wire

/* hdl/shd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shd_checker : port-level checks for the half-step stepper driver
// Watches the request and result channels and the reported motor state.
// ----------------------------------------------------------------------------
module shd_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_stall,
    input wire                          out_valid,
    input wire                          out_stall,
    input wire [3:0]                    coil_pattern,
    input wire                          coil_enable,
    input wire                          step_fired,
    input wire                          is_running
);
    import shd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // requests are held back only while a result is waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("request stalled with empty output");

    // stopped motor shows no drive
    a_stopped_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_running |-> coil_pattern == 4'h0 && !coil_enable && !step_fired)
        else $error("coils driven while stopped");

    // enables follow the run flag
    a_enable_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coil_enable == is_running)
        else $error("enable differs from run flag");

    // a fired step always drives a half-step pattern
    a_step_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_fired |-> coil_pattern != 4'h0 && $countones(coil_pattern) <= 2)
        else $error("step fired without a valid pattern");

endmodule

bind stepper_halfstep_ramp_driver shd_checker u_shd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coil_pattern (coil_pattern),
    .coil_enable  (coil_enable),
    .step_fired   (step_fired),
    .is_running   (is_running)
);
`default_nettype wire
